>>> sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define WSD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define WSD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/wsd_pkg.sv
// shared widths and step counts for the welford sample deviation block
`timescale 1ns / 1ps

package wsd_pkg;

	localparam int SAMPLE_W    = 32;
	localparam int MEAN_EXTRA  = 16;
	localparam int MEAN_W      = SAMPLE_W + MEAN_EXTRA;
	localparam int M2_W        = 64;
	localparam int ROOT_W      = M2_W / 2;
	localparam int MAX_SAMPLES = 65536;
	localparam int CNT_W       = 17;
	localparam int STEP_W      = 7;

	// iteration counts of the shared shift units
	localparam int DIV_MEAN_STEPS = MEAN_W;
	localparam int MUL_STEPS      = MEAN_W;
	localparam int DIV_M2_STEPS   = M2_W;
	localparam int SQRT_STEPS     = ROOT_W;

	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);

endpackage

>>> sv/welford_sample_stdev.sv
// welford running mean and sample standard deviation, bit-serial datapath
// an unsaturated sample without last runs a divide and a multiply before the next accept
// (48 divide steps, 48 multiply steps, idle, update, load, accumulate and finish states)
// a last sample, count two or more, adds a 64-step divide and a 32-step sqrt before the word
// a new sample is taken only in idle; the divider and multiplier work one bit per cycle
// arst_n clears the internal mean, squared sum, count and overflow flag and the result valid
`timescale 1ns / 1ps

module welford_sample_stdev
	import wsd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_stall,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic                last,
	output logic                result_valid,
	input  logic                result_stall,
	output logic [SAMPLE_W-1:0] mean,
	output logic [SAMPLE_W-1:0] deviation,
	output logic [CNT_W-1:0]    sample_count,
	output logic                overflow
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DIVM = 4'd1;
	localparam logic [3:0] ST_UPD  = 4'd2;
	localparam logic [3:0] ST_MLD  = 4'd3;
	localparam logic [3:0] ST_MUL  = 4'd4;
	localparam logic [3:0] ST_ACC  = 4'd5;
	localparam logic [3:0] ST_FIN  = 4'd6;
	localparam logic [3:0] ST_DIVS = 4'd7;
	localparam logic [3:0] ST_SQRT = 4'd8;
	localparam logic [3:0] ST_OUT  = 4'd9;

	logic [3:0]        state_q;
	logic [STEP_W-1:0] step_q;
	logic [MEAN_W-1:0] mean_q;
	logic [M2_W-1:0]   m2_q;
	logic [CNT_W-1:0]  count_q;
	logic              sat_q;
	logic              last_q;
	logic [MEAN_W-1:0] x_q;
	logic [MEAN_W-1:0] magd_q;
	logic              dneg_q;
	logic [CNT_W-1:0]  div_q;
	logic [CNT_W-1:0]  rem_q;
	logic [M2_W-1:0]   work_q;
	logic [MEAN_W-1:0] acc_q;
	logic [ROOT_W-1:0] root_q;

	logic              accept;
	logic [MEAN_W-1:0] x_in;
	logic [MEAN_W:0]   d_full;
	logic [MEAN_W-1:0] magd;
	logic [CNT_W:0]    div_sh;
	logic              div_take;
	logic [MEAN_W-1:0] quot;
	logic [MEAN_W:0]   e_full;
	logic [MEAN_W-1:0] mage;
	logic [MEAN_W:0]   mul_sum;
	logic [M2_W-1:0]   inc;
	logic [M2_W:0]     m2_sum;
	logic [ROOT_W+3:0] sq_rem;
	logic [ROOT_W+3:0] sq_trial;
	logic              sq_take;
	logic              out_free;
	logic              step_end;

	assign accept       = sample_valid && !sample_stall;
	assign sample_stall = (state_q != ST_IDLE);
	assign out_free     = !result_valid || !result_stall;
	assign step_end     = (step_q == '0);

	// sample widened to the mean format, and the signed distance to the mean
	always_comb begin
		x_in   = {sample, {MEAN_EXTRA{1'b0}}};
		d_full = {x_in[MEAN_W-1], x_in} - {mean_q[MEAN_W-1], mean_q};
		magd   = d_full[MEAN_W] ? MEAN_W'(-d_full) : d_full[MEAN_W-1:0];
	end

	// restoring divide step, one quotient bit a cycle
	always_comb begin
		div_sh   = {rem_q, work_q[M2_W-1]};
		div_take = (div_sh >= {1'b0, div_q});
		quot     = work_q[MEAN_W-1:0];
	end

	// distance to the updated mean, multiplier operand
	always_comb begin
		e_full = {x_q[MEAN_W-1], x_q} - {mean_q[MEAN_W-1], mean_q};
		mage   = e_full[MEAN_W] ? MEAN_W'(-e_full) : e_full[MEAN_W-1:0];
	end

	// shift-add multiply step and the saturating squared-sum add
	always_comb begin
		mul_sum = {1'b0, acc_q} + (work_q[0] ? {1'b0, magd_q} : '0);
		inc     = {acc_q, work_q[MEAN_W-1:32]};
		m2_sum  = {1'b0, m2_q} + {1'b0, inc};
	end

	// square root step, two radicand bits a cycle
	always_comb begin
		sq_rem   = {acc_q[ROOT_W+1:0], work_q[M2_W-1:M2_W-2]};
		sq_trial = {2'b00, root_q, 2'b01};
		sq_take  = (sq_rem >= sq_trial);
	end

	// control and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			mean_q  <= '0;
			m2_q    <= '0;
			count_q <= '0;
			sat_q   <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_q <= last;
						if (count_q >= CNT_MAX) begin
							sat_q   <= 1'b1;
							state_q <= ST_FIN;
						end else begin
							step_q  <= STEP_W'(DIV_MEAN_STEPS - 1);
							state_q <= ST_DIVM;
						end
					end
				end
				ST_DIVM: begin
					step_q <= step_q - 1'b1;
					if (step_end) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					mean_q  <= dneg_q ? mean_q - quot : mean_q + quot;
					count_q <= div_q;
					state_q <= ST_MLD;
				end
				ST_MLD: begin
					step_q  <= STEP_W'(MUL_STEPS - 1);
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					step_q <= step_q - 1'b1;
					if (step_end) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (m2_sum[M2_W]) begin
						m2_q  <= '1;
						sat_q <= 1'b1;
					end else begin
						m2_q <= m2_sum[M2_W-1:0];
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (count_q >= CNT_W'(2)) begin
						step_q  <= STEP_W'(DIV_M2_STEPS - 1);
						state_q <= ST_DIVS;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_DIVS: begin
					if (step_end) begin
						step_q  <= STEP_W'(SQRT_STEPS - 1);
						state_q <= ST_SQRT;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				ST_SQRT: begin
					step_q <= step_q - 1'b1;
					if (step_end) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						mean_q  <= '0;
						m2_q    <= '0;
						count_q <= '0;
						sat_q   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// shift registers of the divider, multiplier and square root
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x_q    <= x_in;
				magd_q <= magd;
				dneg_q <= d_full[MEAN_W];
				div_q  <= count_q + 1'b1;
				rem_q  <= '0;
				work_q <= {magd, {(M2_W-MEAN_W){1'b0}}};
			end
			ST_DIVM, ST_DIVS: begin
				rem_q  <= div_take ? CNT_W'(div_sh - {1'b0, div_q}) : div_sh[CNT_W-1:0];
				work_q <= {work_q[M2_W-2:0], div_take};
				if (state_q == ST_DIVS && step_end) begin
					acc_q  <= '0;
					root_q <= '0;
				end
			end
			ST_MLD: begin
				acc_q  <= '0;
				work_q <= {{(M2_W-MEAN_W){1'b0}}, mage};
			end
			ST_MUL: begin
				acc_q  <= mul_sum[MEAN_W:1];
				work_q <= {work_q[M2_W-1:MEAN_W], mul_sum[0], work_q[MEAN_W-1:1]};
			end
			ST_FIN: begin
				div_q  <= count_q - 1'b1;
				rem_q  <= '0;
				work_q <= m2_q;
				root_q <= '0;
			end
			ST_SQRT: begin
				acc_q  <= MEAN_W'(sq_take ? sq_rem - sq_trial : sq_rem);
				root_q <= {root_q[ROOT_W-2:0], sq_take};
				work_q <= {work_q[M2_W-3:0], 2'b00};
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			mean         <= mean_q[MEAN_W-1:MEAN_EXTRA];
			deviation    <= root_q;
			sample_count <= count_q;
			overflow     <= sat_q;
		end
	end

endmodule

>>> sv/wsd_checker.sv
// port-level checks for the welford sample deviation block, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wsd_checker
	import wsd_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                sample_valid,
	input logic                sample_stall,
	input logic                result_valid,
	input logic                result_stall,
	input logic [SAMPLE_W-1:0] mean,
	input logic [SAMPLE_W-1:0] deviation,
	input logic [CNT_W-1:0]    sample_count,
	input logic                overflow
);

	`WSD_ASSERT_NEXT(a_res_hold, result_valid && result_stall, result_valid, "result word dropped while stalled")
	`WSD_ASSERT_NEXT(a_res_stable, result_valid && result_stall, $stable(mean) && $stable(deviation) && $stable(sample_count) && $stable(overflow), "stalled result word changed")
	`WSD_ASSERT_NEXT(a_busy_after_accept, sample_valid && !sample_stall, sample_stall, "sample taken while previous one still in work")
	`WSD_ASSERT_NOW(a_short_dev, result_valid && (sample_count < CNT_W'(2)), deviation == '0, "deviation nonzero for a short series")
	`WSD_ASSERT_NOW(a_count_range, result_valid, (sample_count != '0) && (sample_count <= CNT_MAX), "sample count out of range")

endmodule

bind welford_sample_stdev wsd_checker u_wsd_checker (.*);
